// ===== hdl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IPID_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ipid assertion failed");

// next-cycle implication
`define IPID_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ipid assertion failed");

`endif

// ===== hdl/ipid_pkg.sv =====
package ipid_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned LimitW  = 31;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ErrW    = 33;
  localparam int unsigned AccW    = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPropGain  = 3'd0,
    CfgIntGain   = 3'd1,
    CfgDerivGain = 3'd2,
    CfgSampleTicks = 3'd3,
    CfgOutLimit  = 3'd4
  } cfg_idx_e;

endpackage

// ===== hdl/ipid_req_if.sv =====
interface ipid_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [ipid_pkg::DataW-1:0]   target;
  logic signed [ipid_pkg::DataW-1:0]   measurement;
  logic        [ipid_pkg::DataW-1:0]   now_ticks;

  modport source (output valid, output target, output measurement, output now_ticks,
                  input ready);
  modport sink (input valid, input target, input measurement, input now_ticks,
                output ready);
endinterface

// ===== hdl/ipid_rsp_if.sv =====
interface ipid_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ipid_pkg::DataW-1:0]   drive;
  logic                                updated;

  modport source (output valid, output drive, output updated, input ready);
  modport sink (input valid, input drive, input updated, output ready);
endinterface

// ===== hdl/incremental_pid_controller_unit.sv =====
// Velocity-form PID controller. Each request (target, measurement, now_ticks) gives exactly
// one result: drive, the floor of the Q.FRAC_BITS accumulator, and updated, set when the
// request ran a PID step (new setpoint, or more than sample_ticks ticks elapsed since the
// last step, modulo 2^32). A step adds kp*(e0-e1) + ki*e0 + kd*(e0-2e1+e2) to the
// accumulator with 64-bit saturation at every product and add, then clamps it to
// +-(output_limit << FRAC_BITS). One request is taken every cycle while the result side
// is not stalled; a result passes the input register, then the result register. The three
// gain multipliers, the saturating adders and the clamp form one combinational pass that
// closes the controller state loop, which sets that rate. The user writes gains and limits
// through the cfg port only while the block is idle; the block itself does not enforce it.
module incremental_pid_controller_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipid_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipid_pkg::DataW-1:0]     cfg_wdata_i,
  ipid_req_if.sink                       req_i,
  ipid_rsp_if.source                     rsp_o
);

  localparam int unsigned DataW  = ipid_pkg::DataW;
  localparam int unsigned ErrW   = ipid_pkg::ErrW;
  localparam int unsigned AccW   = ipid_pkg::AccW;
  localparam int unsigned LimitW = ipid_pkg::LimitW;
  localparam int unsigned WideW  = AccW + 3;

  function automatic logic signed [AccW-1:0] sat64(input logic signed [WideW-1:0] v);
    logic signed [AccW-1:0] r;
    if (v[WideW-1:AccW-1] == '0 || v[WideW-1:AccW-1] == '1) begin
      r = v[AccW-1:0];
    end else if (v[WideW-1]) begin
      r = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      r = {1'b0, {(AccW-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration
  logic signed [DataW-1:0]  kp_q, ki_q, kd_q;
  logic        [DataW-1:0]  sample_ticks_q;
  logic        [LimitW-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q           <= '0;
      ki_q           <= '0;
      kd_q           <= '0;
      sample_ticks_q <= '0;
      limit_q        <= '0;
    end else if (cfg_we_i) begin
      case (ipid_pkg::cfg_idx_e'(cfg_idx_i))
        ipid_pkg::CfgPropGain:    kp_q           <= cfg_wdata_i;
        ipid_pkg::CfgIntGain:     ki_q           <= cfg_wdata_i;
        ipid_pkg::CfgDerivGain:   kd_q           <= cfg_wdata_i;
        ipid_pkg::CfgSampleTicks: sample_ticks_q <= cfg_wdata_i;
        ipid_pkg::CfgOutLimit:    limit_q        <= cfg_wdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q, rsp_valid_q, go, req_acc;

  assign go          = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || go;
  assign req_acc     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (go) begin
        rsp_valid_q <= s1_valid_q;
      end
    end
  end

  // input register
  logic signed [DataW-1:0] tgt_q, meas_q;
  logic        [DataW-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      tgt_q  <= req_i.target;
      meas_q <= req_i.measurement;
      now_q  <= req_i.now_ticks;
    end
  end

  // controller state
  logic        [DataW-1:0] last_tick_q;
  logic signed [DataW-1:0] held_target_q;
  logic signed [ErrW-1:0]  err1_q, err2_q;
  logic signed [AccW-1:0]  acc_q;

  logic [DataW-1:0]        elapsed;
  logic                    upd;
  logic signed [ErrW-1:0]  e0;
  logic signed [ErrW:0]    dp;
  logic signed [ErrW+1:0]  dd;
  logic signed [DataW+ErrW:0]   p_full;
  logic signed [DataW+ErrW-1:0] i_full;
  logic signed [DataW+ErrW+1:0] d_full;
  logic signed [AccW-1:0]  p_sat, i_sat, d_sat, pi_sum, term, acc_sum;
  logic signed [AccW-1:0]  lim, neg_lim, acc_clamp, acc_next;

  always_comb begin
    elapsed  = now_q - last_tick_q;
    upd      = (tgt_q != held_target_q) || (elapsed > sample_ticks_q);
    e0       = ErrW'(tgt_q) - ErrW'(meas_q);
    dp       = (ErrW+1)'(e0) - (ErrW+1)'(err1_q);
    dd       = (ErrW+2)'(e0) - ((ErrW+2)'(err1_q) <<< 1) + (ErrW+2)'(err2_q);
    p_full   = (DataW+ErrW+1)'(kp_q) * (DataW+ErrW+1)'(dp);
    i_full   = (DataW+ErrW)'(ki_q) * (DataW+ErrW)'(e0);
    d_full   = (DataW+ErrW+2)'(kd_q) * (DataW+ErrW+2)'(dd);
    p_sat    = sat64(WideW'(p_full));
    i_sat    = sat64(WideW'(i_full));
    d_sat    = sat64(d_full);
    pi_sum   = sat64(WideW'(p_sat) + WideW'(i_sat));
    term     = sat64(WideW'(pi_sum) + WideW'(d_sat));
    acc_sum  = sat64(WideW'(acc_q) + WideW'(term));
    lim      = $signed(AccW'(limit_q) << FRAC_BITS);
    neg_lim  = -lim;
    if (acc_sum > lim) begin
      acc_clamp = lim;
    end else if (acc_sum < neg_lim) begin
      acc_clamp = neg_lim;
    end else begin
      acc_clamp = acc_sum;
    end
    acc_next = upd ? acc_clamp : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tick_q   <= '0;
      held_target_q <= '0;
      err1_q        <= '0;
      err2_q        <= '0;
      acc_q         <= '0;
    end else if (go && s1_valid_q && upd) begin
      last_tick_q   <= now_q;
      held_target_q <= tgt_q;
      err1_q        <= e0;
      err2_q        <= err1_q;
      acc_q         <= acc_clamp;
    end
  end

  // result register
  logic signed [DataW-1:0] drive_q;
  logic                    updated_q;

  always_ff @(posedge clk_i) begin
    if (go && s1_valid_q) begin
      drive_q   <= acc_next[FRAC_BITS +: DataW];
      updated_q <= upd;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.drive   = drive_q;
  assign rsp_o.updated = updated_q;

endmodule

// ===== hdl/ipid_checker.sv =====
`include "assert_macros.svh"

module ipid_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [ipid_pkg::DataW-1:0]   rsp_drive_i,
  input logic                         rsp_updated_i
);

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  // a stalled result holds
  `IPID_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_drive_i) && $stable(rsp_updated_i))

  // an empty result side never blocks requests
  `IPID_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !rsp_valid_i, req_ready_i)

  // a fresh result comes from a request accepted through the input register, then the result register
  `IPID_ASSERT_NOW(a_rsp_from_req, clk_i, rst_ni, $rose(rsp_valid_i), $past(req_acc, 2))

endmodule

bind incremental_pid_controller_unit ipid_checker u_ipid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_drive_i   (rsp_o.drive),
  .rsp_updated_i (rsp_o.updated)
);
